### sv/csmm_pkg.sv
// ----------------------------------------------------------------------------
// csmm_pkg
// Shared constants and types of the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package csmm_pkg;

  // Width of the pixel field on the input channel.
  localparam int PIXEL_PORT_BITS = 16;
  // Default number of pixel bits in use.
  localparam int PIXEL_BITS_DEF  = 16;
  // Width of the stretched result.
  localparam int OUT_BITS        = 8;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 8'd255;
  // Requests that may wait between the front and the back.
  localparam int QUEUE_DEPTH     = 2;

  // Input command codes.
  localparam logic CMD_GATHER = 1'b0;
  localparam logic CMD_MAP    = 1'b1;

  // How the back part finishes a map request.
  typedef enum logic [1:0] {
    OP_ZERO = 2'd0,
    OP_FULL = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

endpackage

### sv/csmm_if.sv
// ----------------------------------------------------------------------------
// csmm_in_if / csmm_out_if
// Valid/ready channels for pixel requests and stretched results.
// ----------------------------------------------------------------------------
interface csmm_in_if
  import csmm_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [PIXEL_PORT_BITS-1:0] pixel;
  logic                       first_pixel;
  logic                       last_pixel;

  modport source (output valid, command, pixel, first_pixel, last_pixel, input ready);
  modport sink   (input valid, command, pixel, first_pixel, last_pixel, output ready);
endinterface

interface csmm_out_if
  import csmm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] stretched;
  logic                last_out;

  modport source (output valid, stretched, last_out, input ready);
  modport sink   (input valid, stretched, last_out, output ready);
endinterface

### sv/csmm_front.sv
// ----------------------------------------------------------------------------
// csmm_front
// Accepts pixel requests, keeps the running minimum and maximum, and turns
// each map request into a self-contained job for the back part.
// ----------------------------------------------------------------------------
module csmm_front
  import csmm_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [PIXEL_PORT_BITS-1:0]          in_pixel,
  input  logic                                in_first_pixel,
  input  logic                                in_last_pixel,
  output logic                                push,
  output logic [2*PIXEL_BITS+$bits(op_t):0]   push_data,
  input  logic                                queue_full
);

  typedef struct packed {
    op_t                   op;
    logic                  last;
    logic [PIXEL_BITS-1:0] diff;
    logic [PIXEL_BITS-1:0] span;
  } entry_t;

  logic [PIXEL_BITS-1:0] min_r, min_nxt;
  logic [PIXEL_BITS-1:0] max_r, max_nxt;
  logic [PIXEL_BITS-1:0] pix;
  logic                  accept;
  entry_t                entry;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign pix      = in_pixel[PIXEL_BITS-1:0];

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (accept && (in_command == CMD_GATHER)) begin
      if (in_first_pixel) begin
        min_nxt = pix;
        max_nxt = pix;
      end else begin
        if (pix < min_r) min_nxt = pix;
        if (pix > max_r) max_nxt = pix;
      end
    end
  end

  // Classify against the levels as they stand at acceptance, so later
  // gathers cannot disturb a job already queued.
  always_comb begin
    entry.last = in_last_pixel;
    entry.diff = pix - min_r;
    entry.span = max_r - min_r;
    priority if (max_r <= min_r) begin
      entry.op = OP_ZERO;
    end else if (pix <= min_r) begin
      entry.op = OP_ZERO;
    end else if (pix >= max_r) begin
      entry.op = OP_FULL;
    end else begin
      entry.op = OP_DIV;
    end
  end

  assign push      = accept && (in_command == CMD_MAP);
  assign push_data = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

### sv/csmm_queue.sv
// ----------------------------------------------------------------------------
// csmm_queue
// Small first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module csmm_queue
  import csmm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### sv/csmm_back.sv
// ----------------------------------------------------------------------------
// csmm_back
// Takes map jobs from the queue, divides (diff * 255) by the span one
// quotient bit a cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
module csmm_back
  import csmm_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                queue_empty,
  input  logic [2*PIXEL_BITS+$bits(op_t):0]   pop_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [OUT_BITS-1:0]                 out_stretched,
  output logic                                out_last_out
);

  localparam int NUM_W = PIXEL_BITS + OUT_BITS;
  localparam int DVS_W = PIXEL_BITS + OUT_BITS - 1;
  localparam int CNT_W = $clog2(OUT_BITS);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(OUT_BITS - 1);

  typedef struct packed {
    op_t                   op;
    logic                  last;
    logic [PIXEL_BITS-1:0] diff;
    logic [PIXEL_BITS-1:0] span;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [NUM_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OUT_BITS-1:0] quo_r, quo_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0] out_q_r, out_q_nxt;
  logic                out_last_r, out_last_nxt;
  entry_t              entry;
  logic                out_free;
  logic                fits;
  logic [NUM_W-1:0]    numer;

  assign entry    = pop_data;
  assign pop      = (state_r == S_IDLE) && !queue_empty;
  assign out_free = !out_valid_r || out_ready;
  // diff * 255 as diff * 256 - diff.
  assign numer    = {entry.diff, {OUT_BITS{1'b0}}} - {{OUT_BITS{1'b0}}, entry.diff};
  assign fits     = (rem_r >= {1'b0, dvs_r});

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    last_nxt      = last_r;
    out_q_nxt     = out_q_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          last_nxt = entry.last;
          unique case (entry.op)
            OP_FULL: begin
              quo_nxt   = OUT_MAX;
              state_nxt = S_DONE;
            end
            OP_DIV: begin
              rem_nxt   = numer;
              dvs_nxt   = {entry.span, {(OUT_BITS-1){1'b0}}};
              cnt_nxt   = CNT_TOP;
              quo_nxt   = '0;
              state_nxt = S_DIV;
            end
            default: begin
              quo_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (fits) rem_nxt = rem_r - {1'b0, dvs_r};
        quo_nxt = {quo_r[OUT_BITS-2:0], fits};
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_q_nxt     = quo_r;
          out_last_nxt  = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
    quo_r      <= quo_nxt;
    last_r     <= last_nxt;
    out_q_r    <= out_q_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_stretched = out_q_r;
  assign out_last_out  = out_last_r;

endmodule

### sv/contrast_stretch_min_max.sv
// ----------------------------------------------------------------------------
// contrast_stretch_min_max
// Min-max contrast stretch: gather statistics, then map pixels to 8 bits.
// ----------------------------------------------------------------------------
// The image is sent twice. Gather requests (command 0) are absorbed by the
// front part in the cycle they are accepted and give no result; first_pixel
// restarts the minimum and maximum. Map requests (command 1) are classified
// against the current levels and queued (two deep) for the back part, which
// produces floor((pixel - min) * 255 / (max - min)) with a restoring divider
// that yields one quotient bit a cycle. The back part fetches a map job in
// its idle state, forms the quotient in its divide state unless the pixel
// is clamped or the image is flat, and hands the result over in its done
// state. The result waits in an output register, so the divider starts on
// the next request while a result is still pending.
module contrast_stretch_min_max
  import csmm_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  csmm_in_if.sink     in_chan,
  csmm_out_if.source  out_chan
);

  localparam int ENTRY_W = 2 * PIXEL_BITS + $bits(op_t) + 1;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic [ENTRY_W-1:0] pop_data;
  logic               queue_full;
  logic               queue_empty;

  csmm_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_command     (in_chan.command),
    .in_pixel       (in_chan.pixel),
    .in_first_pixel (in_chan.first_pixel),
    .in_last_pixel  (in_chan.last_pixel),
    .push           (push),
    .push_data      (push_data),
    .queue_full     (queue_full)
  );

  csmm_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  csmm_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .queue_empty   (queue_empty),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_stretched (out_chan.stretched),
    .out_last_out  (out_chan.last_out)
  );

endmodule

### sv/csmm_checker.sv
// ----------------------------------------------------------------------------
// csmm_checker
// Port-level checks on the contrast stretch block, bound to the top level.
// ----------------------------------------------------------------------------
module csmm_checker
  import csmm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_command,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] out_stretched,
  input logic                out_last_out
);

  // Map requests accepted but not yet delivered. The block can hold at most
  // two in the queue, one in the divider and one in the output register.
  localparam logic [2:0] MAX_PEND = 3'd4;

  logic       map_acc;
  logic       res_acc;
  logic [2:0] pend_r, pend_nxt;

  assign map_acc = in_valid && in_ready && (in_command == CMD_MAP);
  assign res_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (map_acc && !res_acc) pend_nxt = pend_r + 1'b1;
    else if (res_acc && !map_acc) pend_nxt = pend_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_stretched) && $stable(out_last_out))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("result without an outstanding map request");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= MAX_PEND)
    else $error("more map requests in flight than the block can hold");

endmodule

bind contrast_stretch_min_max csmm_checker u_csmm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_command    (in_chan.command),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_stretched (out_chan.stretched),
  .out_last_out  (out_chan.last_out)
);
